### src/msd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msd_pkg: shared types and constants for the stopwatch display
// Digit type, prescaler periods, register indexes and the segment decoder.
// ----------------------------------------------------------------------------
package msd_pkg;

	typedef logic [3:0] digit_t;
	typedef logic [1:0] scan_pos_t;
	typedef logic [6:0] prescale_t;

	localparam int NUM_DIGITS = 4;

	// Prescaler periods in counted ticks
	localparam prescale_t FINE_PERIOD   = 7'd10;
	localparam prescale_t COARSE_PERIOD = 7'd100;

	// Largest BCD digit value
	localparam digit_t DIGIT_MAX = 4'd9;

	// Decimal point position per precision mode
	localparam scan_pos_t DP_POS_FINE   = 2'd1;
	localparam scan_pos_t DP_POS_COARSE = 2'd2;

	// Configuration register indexes
	localparam logic REG_PRECISION_MODE = 1'b0;
	localparam logic REG_DISPLAY_ENABLE = 1'b1;

	// Segment pattern of a BCD digit: bits 0..5 = A..F, bit 6 = G
	function automatic logic [6:0] seg_decode(input digit_t d);
		logic [6:0] pat;
		unique case (d)
			4'd0:    pat = 7'h3F;
			4'd1:    pat = 7'h06;
			4'd2:    pat = 7'h5B;
			4'd3:    pat = 7'h4F;
			4'd4:    pat = 7'h66;
			4'd5:    pat = 7'h6D;
			4'd6:    pat = 7'h7D;
			4'd7:    pat = 7'h07;
			4'd8:    pat = 7'h7F;
			4'd9:    pat = 7'h67;
			default: pat = 7'h00;
		endcase
		return pat;
	endfunction

endpackage

### src/msd_digit_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msd_digit_cell: one BCD digit of the stopwatch count
// Holds a digit, steps it on carry in and passes the carry to the next digit.
// ----------------------------------------------------------------------------
module msd_digit_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            carry_in,
	output logic            carry_out,
	output msd_pkg::digit_t digit
);

	msd_pkg::digit_t digit_q;

	// Wrap on nine and hand the carry on
	assign carry_out = carry_in && (digit_q >= msd_pkg::DIGIT_MAX);
	assign digit     = digit_q;

	// Advance the digit on an incoming carry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else if (carry_in) begin
			if (carry_out) begin
				digit_q <= '0;
			end else begin
				digit_q <= digit_q + 4'd1;
			end
		end
	end

	a_digit_bcd: assert property (@(posedge clk) disable iff (!arst_n)
		digit_q <= msd_pkg::DIGIT_MAX)
		else $error("digit left BCD range");

	a_digit_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		carry_out |=> digit_q == 4'd0)
		else $error("digit did not wrap on carry out");

	a_digit_step: assert property (@(posedge clk) disable iff (!arst_n)
		(carry_in && !carry_out) |=> digit_q == $past(digit_q) + 4'd1)
		else $error("digit did not step on carry in");

endmodule

### src/multiplexed_stopwatch_display.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiplexed_stopwatch_display: four-digit multiplexed stopwatch display
// Scans one digit per 1 ms tick word and counts ticks into a BCD count.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / count_enable): one word per 1 ms
//   tick. count_enable high lets the prescaler and the count run this tick.
//   Output channel (out_valid / out_stall / digit_select, segments_a_to_f,
//   segment_g, decimal_point): one word per tick, showing digit position
//   scan order 0..3 with the count as it stood before that tick.
//   Configuration: cfg_write with cfg_index 0 sets precision_mode (1: count
//   every 10 ticks, point on digit 1; 0: every 100, point on digit 2) and
//   index 1 sets display_enable (0 blanks segments and point).
//   out_valid rises in the cycle after accept. One tick is taken per
//   cycle unless in_stall is high; one output register, four-cell carry chain.
//   When the receiver stalls, the output word holds and in_stall rises while
//   the output register is full; a word is still taken in the cycle the held
//   one leaves. Reset clears the count and scan position, loads the
//   prescaler with 10, sets both registers to 1 and empties the output.
// ----------------------------------------------------------------------------
module multiplexed_stopwatch_display (
	input  logic       clk,
	input  logic       arst_n,
	// tick words
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       count_enable,
	// display words
	output logic       out_valid,
	input  logic       out_stall,
	output logic [3:0] digit_select,
	output logic [5:0] segments_a_to_f,
	output logic       segment_g,
	output logic       decimal_point,
	// configuration
	input  logic       cfg_write,
	input  logic       cfg_index,
	input  logic       cfg_data
);

	logic                  precision_mode_q;
	logic                  display_enable_q;
	msd_pkg::scan_pos_t    scan_pos_q;
	msd_pkg::prescale_t    prescale_q;
	logic                  out_valid_q;
	logic [3:0]            digit_select_q;
	logic [6:0]            segments_q;
	logic                  decimal_point_q;

	logic                  accept;
	logic                  expire;
	logic [msd_pkg::NUM_DIGITS:0] carry;
	msd_pkg::digit_t       digits [msd_pkg::NUM_DIGITS];
	msd_pkg::digit_t       shown_digit;
	msd_pkg::scan_pos_t    dp_pos;
	logic [6:0]            pattern;

	// Hold input while a word waits that cannot leave
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			precision_mode_q <= 1'b1;
			display_enable_q <= 1'b1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				msd_pkg::REG_PRECISION_MODE: precision_mode_q <= cfg_data;
				msd_pkg::REG_DISPLAY_ENABLE: display_enable_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Prescaler: expire on a counted tick at one or below
	assign expire = accept && count_enable && (prescale_q <= 7'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q <= msd_pkg::FINE_PERIOD;
		end else if (accept && count_enable) begin
			if (expire) begin
				prescale_q <= precision_mode_q ? msd_pkg::FINE_PERIOD
				                               : msd_pkg::COARSE_PERIOD;
			end else begin
				prescale_q <= prescale_q - 7'd1;
			end
		end
	end

	// Digit chain: least significant digit at the last position
	assign carry[msd_pkg::NUM_DIGITS] = expire;

	for (genvar i = 0; i < msd_pkg::NUM_DIGITS; i++) begin : g_cell
		msd_digit_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.carry_in  (carry[i+1]),
			.carry_out (carry[i]),
			.digit     (digits[i])
		);
	end

	// Scan position advances on every tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_pos_q <= '0;
		end else if (accept) begin
			scan_pos_q <= scan_pos_q + 2'd1;
		end
	end

	// Decode the scanned digit
	assign shown_digit = digits[scan_pos_q];
	assign pattern     = msd_pkg::seg_decode(shown_digit);
	assign dp_pos      = precision_mode_q ? msd_pkg::DP_POS_FINE : msd_pkg::DP_POS_COARSE;

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			digit_select_q  <= ~(4'b0001 << scan_pos_q);
			segments_q      <= display_enable_q ? pattern : 7'd0;
			decimal_point_q <= display_enable_q && (scan_pos_q == dp_pos);
		end
	end

	assign out_valid       = out_valid_q;
	assign digit_select    = digit_select_q;
	assign segments_a_to_f = segments_q[5:0];
	assign segment_g       = segments_q[6];
	assign decimal_point   = decimal_point_q;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid_q)
		else $error("input stalled with empty output register");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted tick produced no output word");

	a_one_digit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> $countones(digit_select_q) == 3)
		else $error("digit select not a single active digit");

	a_prescale_range: assert property (@(posedge clk) disable iff (!arst_n)
		prescale_q <= msd_pkg::COARSE_PERIOD)
		else $error("prescaler above coarse period");

	a_count_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		carry[0] |=> (digits[0] == 4'd0) && (digits[1] == 4'd0) &&
		             (digits[2] == 4'd0) && (digits[3] == 4'd0))
		else $error("count did not wrap to zero");

endmodule

### bench/tb_multiplexed_stopwatch_display.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multiplexed_stopwatch_display: self-checking bench for the stopwatch display
// Feeds tick words with random count enables and random gaps, stalls the
// display side at random, and checks every display word against a local
// model of the scan, prescaler and BCD count. The run covers both precision
// modes and blanking, a long receiver hold-off and a back-to-back stretch.
// ----------------------------------------------------------------------------
module tb_multiplexed_stopwatch_display;

	// Seven-segment glyphs, bits 0..5 = A..F, bit 6 = G
	localparam logic [6:0] GLYPHS [0:9] = '{
		7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h67
	};

	typedef struct packed {
		logic [3:0] sel;
		logic [5:0] seg;
		logic       g;
		logic       dp;
	} display_word_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic       count_enable;
	logic       out_valid;
	logic       out_stall;
	logic [3:0] digit_select;
	logic [5:0] segments_a_to_f;
	logic       segment_g;
	logic       decimal_point;
	logic       cfg_write;
	logic       cfg_index;
	logic       cfg_data;

	multiplexed_stopwatch_display dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.count_enable    (count_enable),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.digit_select    (digit_select),
		.segments_a_to_f (segments_a_to_f),
		.segment_g       (segment_g),
		.decimal_point   (decimal_point),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	// Local copy of the display state
	logic               fine_mode;
	logic               display_on;
	msd_pkg::scan_pos_t scan_at;
	msd_pkg::prescale_t ticks_left;
	msd_pkg::digit_t    count_digits [msd_pkg::NUM_DIGITS];

	display_word_t expected_display [$];
	int            mismatches;
	bit            tx_idle;
	bit            rx_idle;
	int            hold_cycles;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Gap length: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		else if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Produce the word shown on this tick, then advance scan and count
	function automatic display_word_t predict_display(input logic run);
		display_word_t      w;
		logic [6:0]         pat;
		msd_pkg::digit_t    d;
		msd_pkg::scan_pos_t dp_at;
		bit                 carry;
		d     = count_digits[scan_at];
		pat   = (d <= msd_pkg::DIGIT_MAX) ? GLYPHS[d] : 7'h00;
		dp_at = fine_mode ? msd_pkg::DP_POS_FINE : msd_pkg::DP_POS_COARSE;
		w.sel = ~(4'b0001 << scan_at);
		w.seg = display_on ? pat[5:0] : 6'h00;
		w.g   = display_on ? pat[6] : 1'b0;
		w.dp  = display_on && (scan_at == dp_at);
		scan_at = scan_at + 2'd1;
		if (run) begin
			if (ticks_left <= 7'd1) begin
				carry = 1'b1;
				for (int p = msd_pkg::NUM_DIGITS - 1; p >= 0; p--) begin
					if (carry) begin
						if (count_digits[p] >= msd_pkg::DIGIT_MAX) begin
							count_digits[p] = 4'd0;
						end else begin
							count_digits[p] = count_digits[p] + 4'd1;
							carry = 1'b0;
						end
					end
				end
				ticks_left = fine_mode ? msd_pkg::FINE_PERIOD : msd_pkg::COARSE_PERIOD;
			end else begin
				ticks_left = ticks_left - 7'd1;
			end
		end
		return w;
	endfunction

	// Track accepted ticks and register writes
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_write) begin
				if (cfg_index == msd_pkg::REG_PRECISION_MODE)
					fine_mode = cfg_data;
				else if (cfg_index == msd_pkg::REG_DISPLAY_ENABLE)
					display_on = cfg_data;
			end
			if (in_valid && !in_stall)
				expected_display.push_back(predict_display(count_enable));
		end
	end

	// Compare each accepted display word with the oldest expectation
	always @(posedge clk) begin
		display_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_display.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected word sel=%h seg=%h g=%b dp=%b", $time,
					digit_select, segments_a_to_f, segment_g, decimal_point);
			end else begin
				want = expected_display.pop_front();
				if (digit_select !== want.sel) begin
					mismatches++;
					$display("%0t: digit_select expected %h actual %h", $time,
						want.sel, digit_select);
				end
				if (segments_a_to_f !== want.seg) begin
					mismatches++;
					$display("%0t: segments_a_to_f expected %h actual %h", $time,
						want.seg, segments_a_to_f);
				end
				if (segment_g !== want.g) begin
					mismatches++;
					$display("%0t: segment_g expected %b actual %b", $time,
						want.g, segment_g);
				end
				if (decimal_point !== want.dp) begin
					mismatches++;
					$display("%0t: decimal_point expected %b actual %b", $time,
						want.dp, decimal_point);
				end
			end
		end
	end

	// Display-side stall: random stalls, or a long counted hold-off on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles != 0) begin
				out_stall <= 1'b1;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
				out_stall <= 1'b0;
			end else if (rx_idle && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat (pick_gap() + 1) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Offer one tick word and hold it until taken; idle afterward at random
	task automatic send_tick(input logic run);
		int gap;
		in_valid     <= 1'b1;
		count_enable <= run;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		gap = tx_idle ? pick_gap() : 0;
		if (gap != 0) begin
			in_valid     <= 1'b0;
			count_enable <= 1'($urandom_range(0, 1));
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid and wait until every expected word has come out
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_display.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Write one register while idle
	task automatic set_register(input logic idx, input logic value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	// Scan keeps moving with the count stopped; all zeros, point on digit 1
	task automatic test_stopped_scan();
		repeat (5) send_tick(1'b0);
		wait_idle();
	endtask

	// Fine mode: ten running ticks per increment, then one held tick
	task automatic test_fine_increment();
		repeat (11) send_tick(1'b1);
		send_tick(1'b0);
		wait_idle();
	endtask

	// Blanked display clears segments and point while the count still runs
	task automatic test_blanking();
		set_register(msd_pkg::REG_DISPLAY_ENABLE, 1'b0);
		repeat (4) send_tick(1'b1);
		wait_idle();
		set_register(msd_pkg::REG_DISPLAY_ENABLE, 1'b1);
	endtask

	// Coarse mode moves the point to digit 2; prescaler carries on mid-count
	task automatic test_coarse_point();
		set_register(msd_pkg::REG_PRECISION_MODE, 1'b0);
		repeat (4) send_tick(1'b1);
		wait_idle();
	endtask

	// Random phases, each with its own register setting
	task automatic test_random_phases();
		logic fine;
		logic on;
		for (int ph = 0; ph < 9; ph++) begin
			case (ph)
				0: begin fine = 1'b1; on = 1'b1; end
				1: begin fine = 1'b0; on = 1'b1; end
				2: begin fine = 1'b1; on = 1'b0; end
				3: begin fine = 1'b0; on = 1'b0; end
				default: begin
					fine = ($urandom_range(0, 3) != 0);
					on   = ($urandom_range(0, 4) != 0);
				end
			endcase
			set_register(msd_pkg::REG_PRECISION_MODE, fine);
			set_register(msd_pkg::REG_DISPLAY_ENABLE, on);
			repeat (110) send_tick($urandom_range(0, 7) != 0);
			wait_idle();
		end
	endtask

	// Long receiver hold-off while ticks keep coming, then drain
	task automatic test_backpressure();
		set_register(msd_pkg::REG_PRECISION_MODE, 1'b1);
		set_register(msd_pkg::REG_DISPLAY_ENABLE, 1'b1);
		tx_idle     = 1'b0;
		hold_cycles = 150;
		repeat (60) send_tick($urandom_range(0, 3) != 0);
		wait_idle();
		tx_idle = 1'b1;
	endtask

	// Ticks every cycle with no stalls on either side
	task automatic test_back_to_back();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		repeat (80) send_tick(1'b1);
		wait_idle();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	// Main sequence
	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		count_enable = 1'b0;
		cfg_write    = 1'b0;
		cfg_index    = msd_pkg::REG_PRECISION_MODE;
		cfg_data     = 1'b0;
		mismatches   = 0;
		tx_idle      = 1'b1;
		rx_idle      = 1'b1;
		hold_cycles  = 0;
		fine_mode    = 1'b1;
		display_on   = 1'b1;
		scan_at      = '0;
		ticks_left   = msd_pkg::FINE_PERIOD;
		foreach (count_digits[p])
			count_digits[p] = 4'd0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_stopped_scan();
		test_fine_increment();
		test_blanking();
		test_coarse_point();
		test_random_phases();
		test_backpressure();
		test_back_to_back();

		repeat (10) @(posedge clk);
		if (mismatches == 0 && expected_display.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Watchdog
	initial begin
		#6_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
